FILE: hdl/assert_macros.svh
// assert_macros.svh
// Assertion shorthands for the keyer checker; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/mlk_pkg.sv
// mlk_pkg.sv
// Types, constants and the letter pattern table of the Morse letter keyer.
// No dependencies.
`default_nettype none
package mlk_pkg;

   localparam int CHAR_W        = 8;
   localparam int UNIT_W        = 24;
   localparam int DRIVE_W       = 8;
   localparam int DUR_W         = 26;
   localparam int NUM_LETTERS   = 26;
   localparam int ADDR_W        = $clog2(NUM_LETTERS);
   localparam int LEN_W         = 3;
   localparam int DASH_W        = 8;
   localparam int MAX_ELEMENTS_DEFAULT = 4;

   localparam logic [CHAR_W-1:0]  CHAR_A = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_Z = 8'h5A;
   localparam logic [UNIT_W-1:0]  UNIT_RESET = 24'h01FFFE;

   localparam logic [DRIVE_W-1:0] DRIVE_DOT      = 8'h01;
   localparam logic [DRIVE_W-1:0] DRIVE_DASH     = 8'hFF;
   localparam logic [DRIVE_W-1:0] DRIVE_GAP      = 8'h00;
   localparam logic [DRIVE_W-1:0] DRIVE_CHAR_END = 8'h55;

   // one table entry: element count and dash mask (bit i: element i is a dash)
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [DASH_W-1:0] dash;
   } pattern_type;

   // pattern memory read request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rom_req_type;

   localparam pattern_type PAT_TABLE [NUM_LETTERS] = '{
      '{3'd2, 8'd2},  '{3'd4, 8'd1},  '{3'd4, 8'd5},  '{3'd3, 8'd1},
      '{3'd1, 8'd0},  '{3'd4, 8'd4},  '{3'd3, 8'd3},  '{3'd4, 8'd0},
      '{3'd2, 8'd0},  '{3'd4, 8'd14}, '{3'd3, 8'd5},  '{3'd4, 8'd2},
      '{3'd2, 8'd3},  '{3'd2, 8'd1},  '{3'd3, 8'd7},  '{3'd4, 8'd6},
      '{3'd4, 8'd11}, '{3'd3, 8'd2},  '{3'd3, 8'd0},  '{3'd1, 8'd1},
      '{3'd3, 8'd4},  '{3'd4, 8'd8},  '{3'd3, 8'd6},  '{3'd4, 8'd9},
      '{3'd4, 8'd13}, '{3'd4, 8'd3}
   };

endpackage
`default_nettype wire

FILE: hdl/mlk_pattern_rom.sv
// mlk_pattern_rom.sv
// Synchronous pattern memory with a registered read.
// Depends on mlk_pkg (pattern table and types).
`default_nettype none
module mlk_pattern_rom (
   input  wire logic                 clock,
   input  wire mlk_pkg::rom_req_type rom_req,
   output      mlk_pkg::pattern_type rom_data
);

   localparam mlk_pkg::pattern_type MEM [mlk_pkg::NUM_LETTERS] = mlk_pkg::PAT_TABLE;

   mlk_pkg::pattern_type rd_ff;

   // registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rom_req.en) begin
         rd_ff <= MEM[rom_req.addr];
      end
   end

   assign rom_data = rd_ff;

endmodule
`default_nettype wire

FILE: hdl/mlk_sequencer.sv
// mlk_sequencer.sv
// Step sequencer: accepts a character, reads its pattern, emits drive steps.
// Depends on mlk_pkg; drives mlk_pattern_rom through a request struct.
`default_nettype none
module mlk_sequencer #(
   parameter int MAX_ELEMENTS = mlk_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [mlk_pkg::CHAR_W-1:0]    req_char,
   output      mlk_pkg::rom_req_type          rom_req,
   input  wire mlk_pkg::pattern_type          rom_data,
   input  wire logic [mlk_pkg::UNIT_W-1:0]    unit_ticks,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [mlk_pkg::DRIVE_W-1:0]   rsp_drive,
   output      logic [mlk_pkg::DUR_W-1:0]     rsp_dur,
   output      logic                          rsp_last,
   output      logic                          rsp_bad
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [2:0] {S_IDLE, S_LOOK, S_MARK, S_GAP, S_END} state_type;

   state_type                    state_ff;
   logic                         bad_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             cnt_in;
   logic [MAX_ELEMENTS-1:0]      dash_ff;
   logic                         rsp_valid_ff;
   logic [mlk_pkg::DRIVE_W-1:0]  drive_ff;
   logic [mlk_pkg::DUR_W-1:0]    dur_ff;
   logic                         last_ff;
   logic                         rsp_bad_ff;
   logic                         accept;
   logic                         is_letter;
   logic                         load;
   logic                         emit;
   logic [mlk_pkg::DUR_W-1:0]    dur1;
   logic [mlk_pkg::DUR_W-1:0]    dur2;
   logic [mlk_pkg::DUR_W-1:0]    dur3;
   logic [7:0]                   len8;

   // input handshake and letter check
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_letter  = (req_char >= mlk_pkg::CHAR_A) && (req_char <= mlk_pkg::CHAR_Z);

   // pattern read only for letters, so the address stays in range
   assign rom_req.en   = accept && is_letter;
   assign rom_req.addr = mlk_pkg::ADDR_W'(req_char - mlk_pkg::CHAR_A);

   // element count, cut at MAX_ELEMENTS
   assign len8   = 8'(rom_data.len);
   assign cnt_in = (len8 > 8'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(len8);

   // unit multiples: one, two and three units
   assign dur1 = mlk_pkg::DUR_W'(unit_ticks);
   assign dur2 = {dur1[mlk_pkg::DUR_W-2:0], 1'b0};
   assign dur3 = dur1 + dur2;

   // output register may take a new word when empty or being drained
   assign load = !rsp_valid_ff || rsp_ready;
   assign emit = load && ((state_ff == S_MARK) || (state_ff == S_GAP) || (state_ff == S_END));

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  bad_ff   <= !is_letter;
                  state_ff <= is_letter ? S_LOOK : S_END;
               end
            end
            S_LOOK: begin
               cnt_ff   <= cnt_in;
               dash_ff  <= rom_data.dash[MAX_ELEMENTS-1:0];
               state_ff <= (cnt_in == '0) ? S_END : S_MARK;
            end
            S_MARK: begin
               if (load) begin
                  drive_ff     <= dash_ff[0] ? mlk_pkg::DRIVE_DASH : mlk_pkg::DRIVE_DOT;
                  dur_ff       <= dash_ff[0] ? dur3 : dur1;
                  last_ff      <= 1'b0;
                  rsp_bad_ff   <= bad_ff;
                  state_ff     <= S_GAP;
               end
            end
            S_GAP: begin
               if (load) begin
                  drive_ff     <= mlk_pkg::DRIVE_GAP;
                  dur_ff       <= dur1;
                  last_ff      <= 1'b0;
                  rsp_bad_ff   <= bad_ff;
                  dash_ff      <= dash_ff >> 1;
                  cnt_ff       <= cnt_ff - CNT_W'(1);
                  state_ff     <= (cnt_ff == CNT_W'(1)) ? S_END : S_MARK;
               end
            end
            S_END: begin
               if (load) begin
                  drive_ff     <= mlk_pkg::DRIVE_CHAR_END;
                  dur_ff       <= dur2;
                  last_ff      <= 1'b1;
                  rsp_bad_ff   <= bad_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;
   assign rsp_dur   = dur_ff;
   assign rsp_last  = last_ff;
   assign rsp_bad   = rsp_bad_ff;

endmodule
`default_nettype wire

FILE: hdl/morse_letter_keyer.sv
// morse_letter_keyer
// A character word on req_ (tdata = char_code, ASCII) starts one run of
// drive steps on rsp_. Each step carries drive_value (1 dot, 255 dash,
// 0 element gap, 85 character end) and duration_ticks, the unit count
// times one, two or three. tlast marks the closing character-end step;
// tuser flags a character outside A to Z, whose run is that step alone.
// csr_ writes unit_ticks (clock ticks per Morse unit); write it only
// while no run is in flight.
// Timing: the pattern memory is read on the accept and its data is taken
// in state S_LOOK, then one step leaves per cycle while rsp_tready does not
// stall: each element and its gap, then the closing step; a bad character
// skips the read. There is a single pattern memory read and one output
// register; a new character is taken once the closing step is loaded.
// A stalled rsp_tready holds the current step and the sequence with it.
// Reset (synchronous) empties the output register, returns to idle and
// sets unit_ticks to 131070. No memory clearing pass is needed.
// Depends on mlk_pkg, mlk_pattern_rom and mlk_sequencer.
`default_nettype none
module morse_letter_keyer #(
   parameter int MAX_ELEMENTS = mlk_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   // result words
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // [7:0] drive_value, [33:8] duration_ticks, pad
   output      logic        rsp_tlast,   // last_of_char
   output      logic [0:0]  rsp_tuser,   // [0] bad_char
   // unit_ticks write channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [23:0] csr_wdata
);

   localparam int PAD_W = 40 - mlk_pkg::DRIVE_W - mlk_pkg::DUR_W;

   logic [mlk_pkg::UNIT_W-1:0]  unit_ff;
   mlk_pkg::rom_req_type        rom_req;
   mlk_pkg::pattern_type        rom_data;
   logic [mlk_pkg::DRIVE_W-1:0] drive;
   logic [mlk_pkg::DUR_W-1:0]   dur;
   logic                        bad;

   // unit register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= mlk_pkg::UNIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unit_ff <= csr_wdata;
      end
   end

   mlk_pattern_rom u_rom (
      .clock    (clock),
      .rom_req  (rom_req),
      .rom_data (rom_data)
   );

   mlk_sequencer #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .rom_req    (rom_req),
      .rom_data   (rom_data),
      .unit_ticks (unit_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_drive  (drive),
      .rsp_dur    (dur),
      .rsp_last   (rsp_tlast),
      .rsp_bad    (bad)
   );

   // pack result word
   assign rsp_tdata    = {{PAD_W{1'b0}}, dur, drive};
   assign rsp_tuser[0] = bad;

endmodule
`default_nettype wire

FILE: hdl/mlk_checker.sv
// mlk_checker.sv
// Port-level assertions for morse_letter_keyer, bound to the top level.
// Depends on assert_macros.svh and mlk_pkg.
`default_nettype none
`include "assert_macros.svh"
module mlk_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [0:0]  rsp_tuser
);

   // a stalled result word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result word changed")

   // closing step carries the character-end drive
   `ASSERT_CLK(a_last_drive, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == mlk_pkg::DRIVE_CHAR_END, "last step without character-end drive")

   // a bad character produces only the closing step
   `ASSERT_CLK(a_bad_last, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast, "bad character step not last")

   // no new character while a run is still being sent
   `ASSERT_CLK(a_busy_run, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready, "input ready in the middle of a run")

   // an accepted character closes the input for the next cycle
   `ASSERT_CLK(a_accept_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "input ready right after accept")

endmodule

bind morse_letter_keyer mlk_checker u_mlk_checker (.*);
`default_nettype wire

FILE: test/tb_morse_letter_keyer.sv
`timescale 1ns / 1ps
// tb_morse_letter_keyer.sv
// Self-checking testbench for morse_letter_keyer: directed and random characters
// under several unit settings with random source gaps and sink stalls. Uses mlk_pkg.
module tb_morse_letter_keyer;

   localparam int KEY_MAX_ELEMENTS = mlk_pkg::MAX_ELEMENTS_DEFAULT;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 20;
   localparam logic [mlk_pkg::UNIT_W-1:0] UNIT_AFTER_RESET = 24'd131070;

   // sink stall behaviors
   typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY_OPEN, SINK_MOSTLY_SHUT} sink_mode_type;

   // one drive step as it should leave the keyer
   typedef struct packed {
      logic [mlk_pkg::DRIVE_W-1:0] drive;
      logic [mlk_pkg::DUR_W-1:0]   dur;
      logic                        last;
      logic                        bad;
   } drive_step_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [7:0] drive_value, [33:8] duration_ticks, pad
   logic        rsp_tlast;    // last_of_char
   logic [0:0]  rsp_tuser;    // [0] bad_char
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_wdata;

   drive_step_type             owed_steps[$];
   logic [mlk_pkg::UNIT_W-1:0] unit_mirror;
   int                         fail_count;
   int                         idle_cycles;
   int                         burst_left;
   bit                         offering;
   bit                         pace_off;
   bit                         long_hold_armed;

   morse_letter_keyer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // International Morse for A..Z, element 0 first
   function automatic string morse_of(input int idx);
      case (idx)
         0:  return ".-";    1:  return "-...";  2:  return "-.-.";  3:  return "-..";
         4:  return ".";     5:  return "..-.";  6:  return "--.";   7:  return "....";
         8:  return "..";    9:  return ".---";  10: return "-.-";   11: return ".-..";
         12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
         16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
         20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
         24: return "-.--";  default: return "--..";
      endcase
   endfunction

   function automatic void owe_step(input logic [mlk_pkg::DRIVE_W-1:0] drive, input int units,
                                    input logic last, input logic bad);
      drive_step_type step;
      step.drive = drive;
      step.dur   = mlk_pkg::DUR_W'(unit_mirror * units);
      step.last  = last;
      step.bad   = bad;
      owed_steps.push_back(step);
   endfunction

   // queue the steps one character keys out
   function automatic void key_letter(input logic [7:0] code);
      string pat;
      int    n;
      logic  bad;
      bad = !(code >= mlk_pkg::CHAR_A && code <= mlk_pkg::CHAR_Z);
      if (!bad) begin
         pat = morse_of(int'(code - mlk_pkg::CHAR_A));
         n = pat.len();
         if (n > KEY_MAX_ELEMENTS) n = KEY_MAX_ELEMENTS;
         for (int i = 0; i < n; i++) begin
            if (pat[i] == "-") owe_step(mlk_pkg::DRIVE_DASH, 3, 1'b0, 1'b0);
            else owe_step(mlk_pkg::DRIVE_DOT, 1, 1'b0, 1'b0);
            owe_step(mlk_pkg::DRIVE_GAP, 1, 1'b0, 1'b0);
         end
      end
      owe_step(mlk_pkg::DRIVE_CHAR_END, 2, 1'b1, bad);
   endfunction

   task automatic check_field(input string field, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // monitor: register writes, accepted characters, checked steps, watchdog
   always @(posedge clock) begin : monitor
      drive_step_type want;
      bit             moved;
      if (reset) begin
         owed_steps.delete();
         unit_mirror = UNIT_AFTER_RESET;
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            unit_mirror = csr_wdata;
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            key_letter(req_tdata);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (owed_steps.size() == 0) begin
               $error("result word with no step pending: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = owed_steps.pop_front();
               check_field("drive_value", want.drive, rsp_tdata[7:0]);
               check_field("duration_ticks", want.dur, rsp_tdata[33:8]);
               check_field("tdata_pad", 0, rsp_tdata[39:34]);
               check_field("last_of_char", want.last, rsp_tlast);
               check_field("bad_char", want.bad, rsp_tuser[0]);
            end
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // sink: changing stall pattern, plus one long hold on request
   initial begin : rsp_sink
      sink_mode_type mode;
      int            mode_left;
      int            hold_left;
      rsp_tready = 1'b0;
      mode = SINK_OPEN;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               SINK_OPEN:        rsp_tready <= 1'b1;
               SINK_COIN:        rsp_tready <= ($urandom_range(0, 1) == 0);
               SINK_MOSTLY_OPEN: rsp_tready <= ($urandom_range(0, 7) != 0);
               default:          rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // offer one character; entered and left at a falling edge
   task automatic send_char(input logic [7:0] code);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      offering = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0 || pace_off) begin
         if (burst_left > 0) burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // stop offering and wait for every owed step
   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (owed_steps.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_unit(input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 9) < 8) return mlk_pkg::CHAR_A + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   // unit value left by reset
   task automatic test_reset_unit();
      send_char("E");
      send_char("T");
      send_char("O");
      drain();
   endtask

   // code extremes, range borders, lower case, all-dot and mixed patterns
   task automatic test_char_edges();
      send_char(8'h00);
      send_char(8'hFF);
      send_char("@");
      send_char("A");
      send_char("Z");
      send_char("[");
      send_char("a");
      send_char("z");
      send_char("H");
      send_char("Q");
      drain();
   endtask

   // smallest, largest and zero unit
   task automatic test_unit_extremes();
      write_unit(24'd1);
      send_char("H");
      send_char("O");
      drain();
      write_unit(24'hFFFFFF);
      send_char("Q");
      send_char(8'h80);
      send_char("J");
      drain();
      write_unit(24'd0);
      send_char("B");
      send_char("~");
      drain();
   endtask

   task automatic test_random_traffic(input logic [23:0] unit, input int count);
      write_unit(unit);
      repeat (count) send_char(pick_char());
      drain();
   endtask

   // sink holds off while the source keeps offering, so the keyer backs up
   task automatic test_backpressure();
      pace_off = 1'b1;
      long_hold_armed = 1'b1;
      repeat (24) send_char(mlk_pkg::CHAR_A + 8'($urandom_range(0, 25)));
      pace_off = 1'b0;
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_valid = 1'b0;
      csr_wdata = 24'h000000;
      fail_count = 0;
      burst_left = 0;
      offering = 1'b0;
      pace_off = 1'b0;
      long_hold_armed = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_unit();
      test_char_edges();
      test_unit_extremes();
      test_random_traffic(24'($urandom_range(2, 24'hFFFFFE)), 85);
      test_random_traffic(24'hFFFFFF, 85);
      test_random_traffic(24'd1, 85);
      test_random_traffic(24'($urandom_range(2, 100)), 85);
      test_backpressure();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (owed_steps.size() != 0) begin
         $error("%0d steps never arrived", owed_steps.size());
         fail_count++;
      end
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/mlk_pkg.sv
hdl/mlk_pattern_rom.sv
hdl/mlk_sequencer.sv
hdl/morse_letter_keyer.sv
hdl/mlk_checker.sv
test/tb_morse_letter_keyer.sv
